@@ design/pds_pkg.sv @@
// Shared widths and types for the proper divisor sum block.
`default_nettype none

package pds_pkg;

    localparam int NUMBER_WIDTH  = 32;
    localparam int FIELD_WIDTH   = 32;
    localparam int SUM_WIDTH     = 35;
    localparam int TRIAL_WIDTH   = NUMBER_WIDTH / 2 + 1;
    localparam int SQUARE_WIDTH  = NUMBER_WIDTH + 1;
    localparam int COUNT_WIDTH   = $clog2(NUMBER_WIDTH + 1);
    localparam int S_TDATA_WIDTH = ((FIELD_WIDTH + 7) / 8) * 8;
    localparam int RESULT_WIDTH  = 2 * SUM_WIDTH + 1;
    localparam int M_TDATA_WIDTH = ((RESULT_WIDTH + 7) / 8) * 8;

    typedef struct packed {
        logic                    done;
        logic                    exact;
        logic [NUMBER_WIDTH-1:0] quotient;
    } div_result_t;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] abundance;
        logic                 is_abundant;
        logic [SUM_WIDTH-1:0] divisor_sum;
    } result_t;

endpackage

`default_nettype wire

@@ design/proper_divisor_sum_core.sv @@
// Top level: sum of proper divisors by trial division, with abundance report.
`default_nettype none

// Takes one unsigned number per item and returns the sum of its proper
// divisors, an abundant flag and the excess of the sum over the number
// (0 and 1 give a sum of 0). One number is worked on at a time: trial
// divisors d = 2, 3, ... run while d*d <= number, and each is tested by a
// bit-serial divider that yields one quotient bit per cycle. The result
// sits in an output register, so the next number is accepted while a
// result still waits.
module proper_divisor_sum_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // [31:0] number
    input  wire logic [pds_pkg::S_TDATA_WIDTH-1:0]   s_axis_tdata,
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [34:0] divisor_sum, [35] is_abundant, [70:36] abundance, [71] zero
    output      logic [pds_pkg::M_TDATA_WIDTH-1:0]   m_axis_tdata
);
    import pds_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        TEST,
        DIVIDE,
        FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] num_reg, num_next;
    logic [TRIAL_WIDTH-1:0]  trial_reg, trial_next;
    logic [SQUARE_WIDTH-1:0] square_reg, square_next;
    logic [SUM_WIDTH-1:0]    total_reg, total_next;
    logic                    m_valid_reg, m_valid_next;
    result_t                 m_data_reg, m_data_next;

    logic [NUMBER_WIDTH+FIELD_WIDTH-1:0] in_ext;
    logic [NUMBER_WIDTH-1:0]             in_number;
    logic                                past_bound;
    logic                                div_start;
    div_result_t                         div_res;
    logic [SUM_WIDTH-1:0]                addend;
    logic [SUM_WIDTH+NUMBER_WIDTH-1:0]   sum_wide;
    logic [SUM_WIDTH+NUMBER_WIDTH-1:0]   num_wide;
    logic [SUM_WIDTH+NUMBER_WIDTH-1:0]   excess_wide;
    logic                                abundant;

    assign in_ext    = {{NUMBER_WIDTH{1'b0}}, s_axis_tdata[FIELD_WIDTH-1:0]};
    assign in_number = in_ext[NUMBER_WIDTH-1:0];

    assign past_bound = square_reg > {1'b0, num_reg};
    assign div_start  = (state_reg == TEST) && !past_bound;

    pds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (trial_reg),
        .result   (div_res)
    );

    // square divisor adds itself once
    assign addend = (div_res.quotient == NUMBER_WIDTH'(trial_reg))
                  ? SUM_WIDTH'(trial_reg)
                  : SUM_WIDTH'(div_res.quotient) + SUM_WIDTH'(trial_reg);

    assign sum_wide    = {{NUMBER_WIDTH{1'b0}}, total_reg};
    assign num_wide    = {{SUM_WIDTH{1'b0}}, num_reg};
    assign excess_wide = sum_wide - num_wide;
    assign abundant    = sum_wide > num_wide;

    // hold off the input while in reset
    assign s_axis_tready = aresetn && (state_reg == IDLE);

    always_comb begin
        state_next   = state_reg;
        num_next     = num_reg;
        trial_next   = trial_reg;
        square_next  = square_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE: begin
                if (s_axis_tvalid) begin
                    num_next    = in_number;
                    trial_next  = TRIAL_WIDTH'(2);
                    square_next = SQUARE_WIDTH'(4);
                    total_next  = (in_number < NUMBER_WIDTH'(2)) ? '0 : SUM_WIDTH'(1);
                    state_next  = TEST;
                end
            end
            TEST: begin
                state_next = past_bound ? FINISH : DIVIDE;
            end
            DIVIDE: begin
                if (div_res.done) begin
                    if (div_res.exact) begin
                        total_next = total_reg + addend;
                    end
                    // (d+1)^2 = d^2 + 2d + 1
                    square_next = square_reg + SQUARE_WIDTH'({trial_reg, 1'b1});
                    trial_next  = trial_reg + 1'b1;
                    state_next  = TEST;
                end
            end
            FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.divisor_sum = total_reg;
                    m_data_next.is_abundant = abundant;
                    m_data_next.abundance   = abundant ? excess_wide[SUM_WIDTH-1:0] : '0;
                    state_next              = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
            num_reg     <= '0;
            trial_reg   <= TRIAL_WIDTH'(2);
            square_reg  <= SQUARE_WIDTH'(4);
            total_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            num_reg     <= num_next;
            trial_reg   <= trial_next;
            square_reg  <= square_next;
            total_reg   <= total_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_WIDTH'(m_data_reg);

endmodule

`default_nettype wire

@@ design/pds_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module pds_div (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [pds_pkg::NUMBER_WIDTH-1:0]   dividend,
    input  wire logic [pds_pkg::TRIAL_WIDTH-1:0]    divisor,
    output pds_pkg::div_result_t                    result
);
    import pds_pkg::*;

    logic [NUMBER_WIDTH-1:0] quo_reg;
    logic [TRIAL_WIDTH-1:0]  rem_reg;
    logic [COUNT_WIDTH-1:0]  cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [TRIAL_WIDTH:0]    partial;
    logic [TRIAL_WIDTH:0]    diff;
    logic                    fits;

    // shift the next dividend bit into the partial remainder
    assign partial = {rem_reg, quo_reg[NUMBER_WIDTH-1]};
    assign diff    = partial - {1'b0, divisor};
    assign fits    = partial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= COUNT_WIDTH'(NUMBER_WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == COUNT_WIDTH'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[TRIAL_WIDTH-1:0] : partial[TRIAL_WIDTH-1:0];
            quo_reg <= {quo_reg[NUMBER_WIDTH-2:0], fits};
        end
    end

    assign result.done     = done_reg;
    assign result.exact    = (rem_reg == '0);
    assign result.quotient = quo_reg;

endmodule

`default_nettype wire

@@ design/pds_checker.sv @@
// Port-level checks for the proper divisor sum block, bound to the top level.
`default_nettype none

module pds_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic [pds_pkg::S_TDATA_WIDTH-1:0]   s_axis_tdata,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [pds_pkg::M_TDATA_WIDTH-1:0]   m_axis_tdata
);
    import pds_pkg::*;

    result_t out_item;
    logic    in_take;

    assign out_item = m_axis_tdata[RESULT_WIDTH-1:0];
    assign in_take  = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one number at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> !s_axis_tready)
        else $error("input taken while a number is in work");

    // a new result only appears while a number is in work
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a number in work");

    // abundant flag and excess agree
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (out_item.is_abundant == (out_item.abundance != '0)))
        else $error("abundant flag disagrees with abundance");

endmodule

bind proper_divisor_sum_core pds_checker u_pds_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
